[rtl/arrb_pkg.sv]
// ----------------------------------------------------------------------------
// arrb_pkg: shared types and constants of the autoscaling balancer
// Pool size, field widths, opcodes, register map and payload structs.
// ----------------------------------------------------------------------------
package arrb_pkg;

	localparam int NUM_SERVERS = 4;
	localparam int LOAD_WIDTH  = 16;

	// server index and active-count widths
	localparam int SW = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
	localparam int NW = $clog2(NUM_SERVERS + 1);

	localparam int CAP_W   = 16;
	localparam int PCT_W   = 7;
	localparam int TOTAL_W = 18;
	localparam int IDX_W   = 2;

	// shared multiplier: wide operand times a 7-bit factor
	localparam int AW = (LOAD_WIDTH > CAP_W + NW) ? LOAD_WIDTH : CAP_W + NW;
	localparam int PW = AW + PCT_W;
	localparam int DW = ((AW > TOTAL_W) ? AW : TOTAL_W) + 1;

	localparam logic [SW-1:0]         SRV_LAST  = SW'(NUM_SERVERS - 1);
	localparam logic [LOAD_WIDTH-1:0] LOAD_MAX  = '1;
	localparam logic [TOTAL_W-1:0]    TOTAL_MAX = '1;
	localparam logic [PCT_W-1:0]      PCT_SCALE = 7'd100;

	localparam logic [1:0] OP_ARRIVE = 2'd0;
	localparam logic [1:0] OP_CLOSE  = 2'd1;
	localparam logic [1:0] OP_TICK   = 2'd2;
	localparam logic [1:0] OP_NOP    = 2'd3;

	// APB register map, register i at byte address 4*i
	localparam int ADDR_W    = 4;
	localparam int DATA_W    = 32;
	localparam int REG_IDX_W = ADDR_W - 2;

	localparam logic [REG_IDX_W-1:0] REG_CAPACITY = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_HEADROOM = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_DOWN     = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_UP       = 2'd3;

	localparam logic [CAP_W-1:0] CAPACITY_RST = 16'd100;
	localparam logic [PCT_W-1:0] HEADROOM_RST = 7'd10;
	localparam logic [PCT_W-1:0] DOWN_RST     = 7'd15;
	localparam logic [PCT_W-1:0] UP_RST       = 7'd25;

	typedef struct packed {
		logic [1:0]       opcode;
		logic             connect_ok;
		logic [IDX_W-1:0] close_server;
	} req_t;

	typedef struct packed {
		logic               assigned_valid;
		logic [IDX_W-1:0]   assigned_server;
		logic               scaled_up;
		logic [IDX_W-1:0]   scaled_up_server;
		logic               scaled_down;
		logic [IDX_W-1:0]   removed_server;
		logic [IDX_W-1:0]   migration_target;
		logic [TOTAL_W-1:0] total_load;
	} rsp_t;

	typedef struct packed {
		logic [CAP_W-1:0] capacity;
		logic [PCT_W-1:0] headroom_percent;
		logic [PCT_W-1:0] down_percent;
		logic [PCT_W-1:0] up_percent;
	} cfg_t;

endpackage

[rtl/autoscaling_round_robin_balancer_unit.sv]
// ----------------------------------------------------------------------------
// autoscaling_round_robin_balancer_unit: round-robin balancer with autoscale
// Sequencer over one shared multiplier; per-server loads in one register file.
// ----------------------------------------------------------------------------
// An arrival takes k = 1..NUM_SERVERS round-robin probes; a tick with a single
// active server goes straight to the response. One transaction at a time: a
// new request is taken once the response is registered. Reset clears all
// loads, the total and the pointer, activates server zero only and restores
// the register defaults.
module autoscaling_round_robin_balancer_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  arrb_pkg::req_t              req,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output arrb_pkg::rsp_t              rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [arrb_pkg::ADDR_W-1:0] paddr,
	input  logic [arrb_pkg::DATA_W-1:0] pwdata,
	output logic [arrb_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import arrb_pkg::*;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_ARR_M1   = 4'd1;
	localparam logic [3:0] S_ARR_M2   = 4'd2;
	localparam logic [3:0] S_ARR_M3   = 4'd3;
	localparam logic [3:0] S_ARR_DEC  = 4'd4;
	localparam logic [3:0] S_ARR_RR   = 4'd5;
	localparam logic [3:0] S_CLOSE    = 4'd6;
	localparam logic [3:0] S_TCK_LO   = 4'd7;
	localparam logic [3:0] S_TCK_HI   = 4'd8;
	localparam logic [3:0] S_TCK_CAND = 4'd9;
	localparam logic [3:0] S_TCK_CCHK = 4'd10;
	localparam logic [3:0] S_TCK_TGT  = 4'd11;
	localparam logic [3:0] S_TCK_TCHK = 4'd12;
	localparam logic [3:0] S_TCK_MIG  = 4'd13;
	localparam logic [3:0] S_TCK_CLR  = 4'd14;
	localparam logic [3:0] S_DONE     = 4'd15;

	logic [3:0]            state_q;
	req_t                  req_q;
	rsp_t                  res_q;
	rsp_t                  rsp_q;
	logic                  rsp_valid_q;

	logic [NUM_SERVERS-1:0] active_q;
	logic [LOAD_WIDTH-1:0]  load_q [NUM_SERVERS];
	logic [TOTAL_W-1:0]     total_q;
	logic [SW-1:0]          rr_q;

	logic [AW-1:0]          d_q;
	logic                   d_pos_q;
	logic [PW-1:0]          caph_q;
	logic [PW-1:0]          lo_q;
	logic [PW-1:0]          hi_q;
	logic [SW-1:0]          idx_q;
	logic [SW-1:0]          cnt_q;
	logic [SW-1:0]          i_q;
	logic [SW-1:0]          j_q;
	logic [SW-1:0]          tgt_q;
	logic                   tgt_found_q;
	logic [LOAD_WIDTH-1:0]  cand_q;
	logic [LOAD_WIDTH-1:0]  jl_q;
	logic [AW-1:0]          best_q;

	cfg_t                   cfg;
	logic [AW-1:0]          mul_a;
	logic [PCT_W-1:0]       mul_b;
	logic [PW-1:0]          prod;

	logic [SW-1:0]          rd_addr;
	logic [LOAD_WIDTH-1:0]  rd_data;
	logic                   wr_en;
	logic [LOAD_WIDTH-1:0]  wr_data;
	logic [LOAD_WIDTH:0]    mig_sum;

	logic [NW-1:0]          n_active;
	logic                   free_found;
	logic [SW-1:0]          free_idx;
	logic                   cs_in_range;
	logic [SW-1:0]          cs_idx;
	logic [DW-1:0]          d_full;
	logic                   d_pos;
	logic                   scale;
	logic                   tgt_ok;

	arrb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	arrb_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign n_active    = NW'($countones(active_q));
	assign cs_in_range = (32'(req_q.close_server) < NUM_SERVERS);
	assign cs_idx      = SW'(req_q.close_server);

	// slack = capacity*active - total; scale up when it is not positive or
	// when floor(capacity*headroom/100) >= slack, i.e. capacity*headroom >= 100*slack
	assign d_full = DW'(prod) - DW'(total_q);
	assign d_pos  = !d_full[DW-1] && (d_full != '0);
	assign scale  = !d_pos_q || (caph_q >= prod);

	assign tgt_ok = (j_q != i_q) && active_q[j_q] && (prod >= lo_q) && (prod < hi_q)
	              && (AW'(jl_q) < best_q);

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int k = NUM_SERVERS - 1; k >= 0; k--) begin
			if (!active_q[k]) begin
				free_found = 1'b1;
				free_idx   = SW'(k);
			end
		end
	end

	always_comb begin
		unique case (state_q)
			S_ARR_RR:                 rd_addr = idx_q;
			S_CLOSE:                  rd_addr = cs_idx;
			S_TCK_TGT:                rd_addr = j_q;
			S_TCK_MIG:                rd_addr = tgt_q;
			default:                  rd_addr = i_q;
		endcase
	end

	assign rd_data = load_q[rd_addr];
	assign mig_sum = {1'b0, rd_data} + {1'b0, cand_q};

	always_comb begin
		wr_en   = 1'b0;
		wr_data = rd_data;
		unique case (state_q)
			S_ARR_RR: begin
				wr_en   = active_q[idx_q] && req_q.connect_ok && (rd_data != LOAD_MAX);
				wr_data = rd_data + 1'b1;
			end
			S_CLOSE: begin
				wr_en   = cs_in_range && (rd_data != '0);
				wr_data = rd_data - 1'b1;
			end
			S_TCK_MIG: begin
				wr_en   = tgt_found_q;
				wr_data = mig_sum[LOAD_WIDTH] ? LOAD_MAX : mig_sum[LOAD_WIDTH-1:0];
			end
			S_TCK_CLR: begin
				wr_en   = 1'b1;
				wr_data = '0;
			end
			default: begin
				wr_en   = 1'b0;
				wr_data = rd_data;
			end
		endcase
	end

	always_comb begin
		unique case (state_q)
			S_ARR_M1: begin
				mul_a = AW'(cfg.capacity);
				mul_b = PCT_W'(n_active);
			end
			S_ARR_M2: begin
				mul_a = AW'(cfg.capacity);
				mul_b = cfg.headroom_percent;
			end
			S_ARR_M3: begin
				mul_a = d_q;
				mul_b = PCT_SCALE;
			end
			S_TCK_LO: begin
				mul_a = AW'(cfg.capacity);
				mul_b = cfg.down_percent;
			end
			S_TCK_HI: begin
				mul_a = AW'(cfg.capacity);
				mul_b = cfg.up_percent;
			end
			S_TCK_CAND, S_TCK_TGT: begin
				mul_a = AW'(rd_data);
				mul_b = PCT_SCALE;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_SERVERS; k++) begin
				load_q[k] <= '0;
			end
		end else if (wr_en) begin
			load_q[rd_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			active_q    <= NUM_SERVERS'(1);
			total_q     <= '0;
			rr_q        <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
			req_q       <= '0;
			res_q       <= '0;
			d_q         <= '0;
			d_pos_q     <= 1'b0;
			caph_q      <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			idx_q       <= '0;
			cnt_q       <= '0;
			i_q         <= '0;
			j_q         <= '0;
			tgt_q       <= '0;
			tgt_found_q <= 1'b0;
			cand_q      <= '0;
			jl_q        <= '0;
			best_q      <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall && (state_q != S_DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						req_q <= req;
						res_q <= '0;
						i_q   <= '0;
						unique case (req.opcode)
							OP_ARRIVE: state_q <= S_ARR_M1;
							OP_CLOSE:  state_q <= S_CLOSE;
							OP_TICK:   state_q <= (n_active > NW'(1)) ? S_TCK_LO : S_DONE;
							OP_NOP:    state_q <= S_DONE;
						endcase
					end
				end
				S_ARR_M1: begin
					state_q <= S_ARR_M2;
				end
				S_ARR_M2: begin
					d_q     <= AW'(d_full);
					d_pos_q <= d_pos;
					state_q <= S_ARR_M3;
				end
				S_ARR_M3: begin
					caph_q  <= prod;
					state_q <= S_ARR_DEC;
				end
				S_ARR_DEC: begin
					cnt_q <= '0;
					if (scale && free_found) begin
						active_q[free_idx]     <= 1'b1;
						rr_q                   <= '0;
						idx_q                  <= '0;
						res_q.scaled_up        <= 1'b1;
						res_q.scaled_up_server <= IDX_W'(free_idx);
					end else begin
						idx_q <= rr_q;
					end
					state_q <= S_ARR_RR;
				end
				S_ARR_RR: begin
					if (active_q[idx_q]) begin
						rr_q                  <= (idx_q == SRV_LAST) ? '0 : idx_q + 1'b1;
						res_q.assigned_valid  <= 1'b1;
						res_q.assigned_server <= IDX_W'(idx_q);
						if (req_q.connect_ok && (total_q != TOTAL_MAX)) begin
							total_q <= total_q + 1'b1;
						end
						state_q <= S_DONE;
					end else if (cnt_q == SRV_LAST) begin
						state_q <= S_DONE;
					end else begin
						idx_q <= (idx_q == SRV_LAST) ? '0 : idx_q + 1'b1;
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_CLOSE: begin
					if (cs_in_range && (total_q != '0)) begin
						total_q <= total_q - 1'b1;
					end
					state_q <= S_DONE;
				end
				S_TCK_LO: begin
					state_q <= S_TCK_HI;
				end
				S_TCK_HI: begin
					lo_q    <= prod;
					state_q <= S_TCK_CAND;
				end
				S_TCK_CAND: begin
					// first visit comes straight from the upper-bound multiply
					if (i_q == '0) begin
						hi_q <= prod;
					end
					cand_q  <= rd_data;
					state_q <= S_TCK_CCHK;
				end
				S_TCK_CCHK: begin
					if (active_q[i_q] && (prod < lo_q)) begin
						j_q         <= '0;
						best_q      <= AW'(cfg.capacity);
						tgt_found_q <= 1'b0;
						state_q     <= S_TCK_TGT;
					end else if (i_q == SRV_LAST) begin
						state_q <= S_DONE;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_TCK_CAND;
					end
				end
				S_TCK_TGT: begin
					jl_q    <= rd_data;
					state_q <= S_TCK_TCHK;
				end
				S_TCK_TCHK: begin
					if (tgt_ok) begin
						best_q      <= AW'(jl_q);
						tgt_q       <= j_q;
						tgt_found_q <= 1'b1;
					end
					if (j_q == SRV_LAST) begin
						state_q <= S_TCK_MIG;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= S_TCK_TGT;
					end
				end
				S_TCK_MIG: begin
					if (tgt_found_q) begin
						state_q <= S_TCK_CLR;
					end else if (i_q == SRV_LAST) begin
						state_q <= S_DONE;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_TCK_CAND;
					end
				end
				S_TCK_CLR: begin
					active_q[i_q]          <= 1'b0;
					res_q.scaled_down      <= 1'b1;
					res_q.removed_server   <= IDX_W'(i_q);
					res_q.migration_target <= IDX_W'(tgt_q);
					state_q                <= S_DONE;
				end
				S_DONE: begin
					// hold until the output register is free
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q       <= {res_q[$bits(rsp_t)-1:TOTAL_W], total_q};
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/arrb_mul.sv]
// ----------------------------------------------------------------------------
// arrb_mul: shared multiplier of the balancer
// Wide operand times a 7-bit factor, product registered.
// ----------------------------------------------------------------------------
module arrb_mul (
	input  logic                     clk,
	input  logic [arrb_pkg::AW-1:0]    a,
	input  logic [arrb_pkg::PCT_W-1:0] b,
	output logic [arrb_pkg::PW-1:0]    prod
);
	import arrb_pkg::*;

	always_ff @(posedge clk) begin
		prod <= PW'(a) * PW'(b);
	end

endmodule

[rtl/arrb_regs.sv]
// ----------------------------------------------------------------------------
// arrb_regs: configuration registers of the balancer
// APB-style write and read of capacity and the three percent thresholds.
// ----------------------------------------------------------------------------
module arrb_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [arrb_pkg::ADDR_W-1:0] paddr,
	input  logic [arrb_pkg::DATA_W-1:0] pwdata,
	output logic [arrb_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output arrb_pkg::cfg_t              cfg
);
	import arrb_pkg::*;

	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;
	cfg_t                 cfg_q;

	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.capacity         <= CAPACITY_RST;
			cfg_q.headroom_percent <= HEADROOM_RST;
			cfg_q.down_percent     <= DOWN_RST;
			cfg_q.up_percent       <= UP_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_CAPACITY: cfg_q.capacity         <= pwdata[CAP_W-1:0];
				REG_HEADROOM: cfg_q.headroom_percent <= pwdata[PCT_W-1:0];
				REG_DOWN:     cfg_q.down_percent     <= pwdata[PCT_W-1:0];
				REG_UP:       cfg_q.up_percent       <= pwdata[PCT_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_CAPACITY: prdata = DATA_W'(cfg_q.capacity);
			REG_HEADROOM: prdata = DATA_W'(cfg_q.headroom_percent);
			REG_DOWN:     prdata = DATA_W'(cfg_q.down_percent);
			REG_UP:       prdata = DATA_W'(cfg_q.up_percent);
		endcase
	end

endmodule

[rtl/arrb_checker.sv]
// ----------------------------------------------------------------------------
// arrb_checker: port-level assertions of the balancer
// Watches the request and response channels; bound to the top level.
// ----------------------------------------------------------------------------
module arrb_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input arrb_pkg::rsp_t rsp
);
	import arrb_pkg::*;

	// one transaction in flight: busy right after a request is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted while a transaction was in flight");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	// a newly activated server leaves at least one candidate for round robin
	a_scale_assigns: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.scaled_up |-> rsp.assigned_valid)
		else $error("scale-up without an assigned server");

	a_retire_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.scaled_down |->
			rsp.removed_server != rsp.migration_target && !rsp.assigned_valid
			&& !rsp.scaled_up)
		else $error("retired server migrated onto itself or mixed with arrival");

endmodule

bind autoscaling_round_robin_balancer_unit arrb_checker u_arrb_checker (.*);

[dv/arrb_scoreboard_pkg.sv]
// ----------------------------------------------------------------------------
// arrb_scoreboard_pkg: expected-response tracking for the balancer testbench
// Keeps its own copy of the server pool, the pointer and the registers,
// computes the response of every accepted request and checks the block's
// responses against them in order.
// ----------------------------------------------------------------------------
package arrb_scoreboard_pkg;

	import arrb_pkg::*;

	class balancer_scoreboard;

		logic [CAP_W-1:0]      capacity;
		logic [PCT_W-1:0]      headroom;
		logic [PCT_W-1:0]      down_pct;
		logic [PCT_W-1:0]      up_pct;
		bit                    active [NUM_SERVERS];
		logic [LOAD_WIDTH-1:0] load [NUM_SERVERS];
		logic [TOTAL_W-1:0]    total;
		int unsigned           rr;
		rsp_t                  expected_rsp [$];
		int unsigned           errors;

		function new();
			capacity = CAPACITY_RST;
			headroom = HEADROOM_RST;
			down_pct = DOWN_RST;
			up_pct   = UP_RST;
			foreach (load[i]) begin
				load[i]   = '0;
				active[i] = (i == 0);
			end
			total  = '0;
			rr     = 0;
			errors = 0;
		endfunction

		function void write_reg(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
			case (idx)
				REG_CAPACITY: capacity = value[CAP_W-1:0];
				REG_HEADROOM: headroom = value[PCT_W-1:0];
				REG_DOWN:     down_pct = value[PCT_W-1:0];
				REG_UP:       up_pct   = value[PCT_W-1:0];
				default: ;
			endcase
		endfunction

		function int live_servers();
			int n;
			n = 0;
			foreach (active[i])
				if (active[i])
					n++;
			return n;
		endfunction

		// Advance the pool by one accepted request and queue its response.
		function void note_event(req_t r);
			rsp_t        e;
			longint      thr;
			longint      lo;
			longint      hi;
			longint      best;
			longint      sum;
			int          tgt;
			bit          found;
			int unsigned idx;
			e     = '0;
			found = 1'b0;
			case (r.opcode)
				OP_ARRIVE: begin
					thr = longint'(capacity) * live_servers()
					    - longint'(capacity) * longint'(headroom) / 100;
					if (longint'(total) >= thr) begin
						for (int i = 0; i < NUM_SERVERS; i++) begin
							if (!found && !active[i]) begin
								active[i]          = 1'b1;
								rr                 = 0;
								e.scaled_up        = 1'b1;
								e.scaled_up_server = IDX_W'(i);
								found              = 1'b1;
							end
						end
					end
					found = 1'b0;
					for (int k = 0; k < NUM_SERVERS; k++) begin
						idx = (rr + k) % NUM_SERVERS;
						if (!found && active[idx]) begin
							found             = 1'b1;
							rr                = (idx + 1) % NUM_SERVERS;
							e.assigned_valid  = 1'b1;
							e.assigned_server = IDX_W'(idx);
							if (r.connect_ok) begin
								if (load[idx] != LOAD_MAX)
									load[idx]++;
								if (total != TOTAL_MAX)
									total++;
							end
						end
					end
				end
				OP_CLOSE: begin
					if (load[r.close_server] != '0)
						load[r.close_server]--;
					if (total != '0)
						total--;
				end
				OP_TICK: begin
					if (live_servers() > 1) begin
						lo = longint'(down_pct) * longint'(capacity);
						hi = longint'(up_pct) * longint'(capacity);
						for (int i = 0; i < NUM_SERVERS; i++) begin
							if (!found && active[i] && longint'(load[i]) * 100 < lo) begin
								best = longint'(capacity);
								tgt  = -1;
								for (int j = 0; j < NUM_SERVERS; j++) begin
									if (j != i && active[j]
									    && longint'(load[j]) * 100 >= lo
									    && longint'(load[j]) * 100 < hi
									    && longint'(load[j]) < best) begin
										best = longint'(load[j]);
										tgt  = j;
									end
								end
								// no target: keep scanning later candidates
								if (tgt >= 0) begin
									sum = longint'(load[tgt]) + longint'(load[i]);
									load[tgt] = (sum > longint'(LOAD_MAX)) ? LOAD_MAX
									                                       : LOAD_WIDTH'(sum);
									load[i]            = '0;
									active[i]          = 1'b0;
									e.scaled_down      = 1'b1;
									e.removed_server   = IDX_W'(i);
									e.migration_target = IDX_W'(tgt);
									found              = 1'b1;
								end
							end
						end
					end
				end
				default: ;
			endcase
			e.total_load = total;
			expected_rsp.push_back(e);
		endfunction

		task report(string msg);
			errors++;
			$display("mismatch: %s", msg);
		endtask

		task compare_field(string name, logic [TOTAL_W-1:0] got, logic [TOTAL_W-1:0] exp);
			if (got !== exp)
				report($sformatf("%s got %0d expected %0d", name, got, exp));
		endtask

		task check_rsp(rsp_t got);
			rsp_t e;
			if (expected_rsp.size() == 0) begin
				report($sformatf("response with nothing pending, total_load %0d",
				                 got.total_load));
				return;
			end
			e = expected_rsp.pop_front();
			compare_field("assigned_valid", got.assigned_valid, e.assigned_valid);
			compare_field("assigned_server", got.assigned_server, e.assigned_server);
			compare_field("scaled_up", got.scaled_up, e.scaled_up);
			compare_field("scaled_up_server", got.scaled_up_server, e.scaled_up_server);
			compare_field("scaled_down", got.scaled_down, e.scaled_down);
			compare_field("removed_server", got.removed_server, e.removed_server);
			compare_field("migration_target", got.migration_target, e.migration_target);
			compare_field("total_load", got.total_load, e.total_load);
		endtask

	endclass

endpackage

[dv/tb_autoscaling_round_robin_balancer_unit.sv]
// ----------------------------------------------------------------------------
// tb_autoscaling_round_robin_balancer_unit: balancer regression
// Directed arrivals, closes, ticks and no-ops, then random traffic over a
// range of register settings with random idling on both channels. Every
// response is checked field by field against the scoreboard.
// ----------------------------------------------------------------------------
module tb_autoscaling_round_robin_balancer_unit;

	timeunit 1ns;
	timeprecision 1ps;

	import arrb_pkg::*;
	import arrb_scoreboard_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned SETTLE_CYCLES = 64;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_stall;
	req_t              req       = '0;
	logic              rsp_valid;
	logic              rsp_stall = 1'b0;
	rsp_t              rsp;
	logic              psel      = 1'b0;
	logic              penable   = 1'b0;
	logic              pwrite    = 1'b0;
	logic [ADDR_W-1:0] paddr     = '0;
	logic [DATA_W-1:0] pwdata    = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	int unsigned        snd_idle_pct = 0;
	int unsigned        rcv_idle_pct = 0;
	int unsigned        cycle_count  = 0;
	balancer_scoreboard sb;

	autoscaling_round_robin_balancer_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("autoscaling_round_robin_balancer_unit regression: fail");
		$finish;
	end

	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_rsp(rsp);
	end

	function automatic req_t make_req(logic [1:0] op, logic ok, logic [IDX_W-1:0] srv);
		req_t r;
		r.opcode       = op;
		r.connect_ok   = ok;
		r.close_server = srv;
		return r;
	endfunction

	// Entered and left at a falling edge; valid stays high into the next call.
	task automatic send_request(req_t r);
		int unsigned gap;
		gap = 0;
		while ($urandom_range(99) < snd_idle_pct)
			gap++;
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (req_stall);
		sb.note_event(r);
		@(negedge clk);
	endtask

	// Hold psel across back-to-back transfers; the caller drops it.
	task automatic apb_access(bit wr, logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] wdata,
	                          output logic [DATA_W-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		if (wr)
			sb.write_reg(idx, wdata);
		@(negedge clk);
	endtask

	task automatic settle();
		req_valid <= 1'b0;
		while (sb.expected_rsp.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic configure(int unsigned cap, int unsigned head, int unsigned down,
	                         int unsigned up);
		logic [REG_IDX_W-1:0] regs [4];
		logic [DATA_W-1:0]    values [4];
		logic [DATA_W-1:0]    rd;
		regs   = '{REG_CAPACITY, REG_HEADROOM, REG_DOWN, REG_UP};
		values = '{DATA_W'(cap), DATA_W'(head), DATA_W'(down), DATA_W'(up)};
		for (int i = 0; i < 4; i++)
			apb_access(1'b1, regs[i], values[i], rd);
		for (int i = 0; i < 4; i++) begin
			apb_access(1'b0, regs[i], '0, rd);
			if (rd !== values[i])
				sb.report($sformatf("register %0d read %0h expected %0h",
				                    regs[i], rd, values[i]));
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin
		int unsigned cap_set   [7] = '{10, 4, 1, 65535, 0, 3, 8};
		int unsigned head_set  [7] = '{10, 0, 100, 0, 50, 50, 100};
		int unsigned down_set  [7] = '{15, 50, 100, 0, 20, 30, 40};
		int unsigned up_set    [7] = '{25, 100, 100, 0, 60, 80, 100};
		int unsigned count_set [7] = '{110, 110, 40, 30, 30, 110, 110};
		int unsigned mode_set  [7] = '{0, 0, 1, 1, 1, 2, 2};
		int unsigned roll;
		bit          heavy;
		req_t        r;

		sb = new();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: no-op, closes at zero load, tick with one server, arrivals
		send_request(make_req(OP_NOP, 1'b1, 2'd3));
		send_request(make_req(OP_CLOSE, 1'b0, 2'd0));
		send_request(make_req(OP_TICK, 1'b1, 2'd1));
		send_request(make_req(OP_ARRIVE, 1'b0, 2'd2));
		send_request(make_req(OP_ARRIVE, 1'b1, 2'd1));
		send_request(make_req(OP_ARRIVE, 1'b1, 2'd0));
		send_request(make_req(OP_ARRIVE, 1'b1, 2'd3));
		send_request(make_req(OP_CLOSE, 1'b1, 2'd3));
		send_request(make_req(OP_CLOSE, 1'b0, 2'd2));

		// tiny capacity: scale up to a full pool, then migrate and retire
		settle();
		configure(2, 0, 50, 100);
		repeat (6) send_request(make_req(OP_ARRIVE, 1'b1, 2'd0));
		send_request(make_req(OP_TICK, 1'b0, 2'd0));
		send_request(make_req(OP_CLOSE, 1'b0, 2'd1));
		send_request(make_req(OP_TICK, 1'b0, 2'd0));
		send_request(make_req(OP_CLOSE, 1'b1, 2'd0));
		send_request(make_req(OP_CLOSE, 1'b1, 2'd0));
		send_request(make_req(OP_ARRIVE, 1'b1, 2'd2));

		for (int p = 0; p < 7; p++) begin
			settle();
			configure(cap_set[p], head_set[p], down_set[p], up_set[p]);
			case (mode_set[p])
				0: begin
					snd_idle_pct = 22;
					rcv_idle_pct = 65;
				end
				1: begin
					snd_idle_pct = 65;
					rcv_idle_pct = 22;
				end
				default: begin
					snd_idle_pct = 0;
					rcv_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < count_set[p]; n++) begin
				// fill the pool first, then drain it so ticks find underused servers
				heavy          = (n < count_set[p] * 3 / 5);
				roll           = $urandom_range(99);
				r.connect_ok   = ($urandom_range(99) < 85);
				r.close_server = IDX_W'($urandom_range(3));
				if (roll < (heavy ? 60 : 25))
					r.opcode = OP_ARRIVE;
				else if (roll < (heavy ? 80 : 70))
					r.opcode = OP_CLOSE;
				else if (roll < 95)
					r.opcode = OP_TICK;
				else
					r.opcode = OP_NOP;
				send_request(r);
			end
		end

		settle();
		if (sb.errors == 0)
			$display("autoscaling_round_robin_balancer_unit regression: pass");
		else
			$display("autoscaling_round_robin_balancer_unit regression: fail");
		$finish;
	end

endmodule

[sim.f]
rtl/arrb_pkg.sv
rtl/arrb_mul.sv
rtl/arrb_regs.sv
rtl/autoscaling_round_robin_balancer_unit.sv
rtl/arrb_checker.sv
dv/arrb_scoreboard_pkg.sv
dv/tb_autoscaling_round_robin_balancer_unit.sv
